@@ rtl/msis_pkg.sv @@
// Shared types and constants for the merge-insertion sorter.
`timescale 1ns / 1ps

package msis_pkg;

    localparam int unsigned SLOTS_DEF = 32;
    localparam int unsigned VALUE_W   = 31;

    typedef logic [VALUE_W-1:0] value_t;

    typedef enum logic {
        ST_LOAD,
        ST_DRAIN
    } state_t;

    // Command seen by every cell of the chain in the same cycle.
    typedef struct packed {
        logic insert;
        logic shift;
    } cell_ctrl_t;

endpackage

@@ rtl/msis_cell.sv @@
// One cell of the sorting chain: holds a value, inserts or shifts toward cell 0.
`timescale 1ns / 1ps

module msis_cell (
    input  logic                 aclk,
    input  msis_pkg::cell_ctrl_t ctrl,
    input  logic                 occupied,
    input  msis_pkg::value_t     new_value,
    input  msis_pkg::value_t     prev_value,
    input  logic                 prev_gt,
    input  msis_pkg::value_t     next_value,
    output msis_pkg::value_t     value_out,
    output logic                 gt_out
);

    msis_pkg::value_t value_reg;
    msis_pkg::value_t value_next;

    // New value belongs at or before this cell.
    assign gt_out    = !occupied || (new_value < value_reg);
    assign value_out = value_reg;

    always_comb begin
        value_next = value_reg;
        if (ctrl.shift) begin
            value_next = next_value;
        end else if (ctrl.insert && gt_out) begin
            // Take the new value at the boundary, else make room by taking the left neighbor.
            value_next = prev_gt ? prev_value : new_value;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

endmodule

@@ rtl/merge_insertion_sorter_unit.sv @@
// Top level of the merge-insertion sorter: insertion chain, run control, output register.
`timescale 1ns / 1ps

// Usage
//   Input channel (s_valid/s_ready, s_value, s_last): one request per value.
//   Each accepted value that finds room is placed in a sorted chain of
//   SLOTS cells in the cycle it arrives, so loading runs at one request per
//   cycle. A request with s_last set closes the set and is stored likewise.
//   Result channel (m_valid/m_ready, m_sorted_value, m_end_of_run,
//   m_overflow): after the closing request the stored values come out in
//   ascending order, one per cycle while m_ready is high; m_end_of_run marks
//   the final one, m_overflow is set on every result of a set that lost
//   values to a full chain. The first result enters the output register
//   once the state has turned to draining after the closing request.
//   The loading rate is set by the single compare-and-select in each cell,
//   which sees the broadcast value and its left neighbor's compare flag.
//   While results drain, s_ready is low; it returns in the same cycle as
//   the final result enters the output register, which parts the two sides.
//   With a result waiting and m_ready low, the output register and chain hold.
//   Reset (aresetn low, synchronous) empties the chain, clears the overflow
//   flag and the output valid; stored values need no clearing.

module merge_insertion_sorter_unit #(
    parameter int unsigned SLOTS = msis_pkg::SLOTS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [msis_pkg::VALUE_W-1:0]  s_value,
    input  logic                          s_last,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [msis_pkg::VALUE_W-1:0]  m_sorted_value,
    output logic                          m_end_of_run,
    output logic                          m_overflow
);

    localparam int unsigned CNT_W = $clog2(SLOTS + 1);

    msis_pkg::state_t     state_reg, state_next;
    logic [CNT_W-1:0]     fill_count_reg, fill_count_next;
    logic                 dropped_reg, dropped_next;
    logic                 m_valid_reg, m_valid_next;
    msis_pkg::value_t     m_value_reg, m_value_next;
    logic                 m_end_reg, m_end_next;
    logic                 m_ovf_reg, m_ovf_next;

    logic                 accept;
    logic                 full;
    logic                 pop;
    msis_pkg::cell_ctrl_t ctrl;

    msis_pkg::value_t     cell_value [SLOTS];
    logic                 cell_gt    [SLOTS];

    assign accept = s_valid && s_ready;
    assign full   = (fill_count_reg == CNT_W'(SLOTS));
    // While draining, move the head of the chain into the output register when it is free or being read.
    assign pop    = (state_reg == msis_pkg::ST_DRAIN) && (!m_valid_reg || m_ready);

    assign ctrl.insert = accept && !full;
    assign ctrl.shift  = pop;

    // Chain of cells, cell 0 holds the smallest value.
    for (genvar i = 0; i < SLOTS; i++) begin : g_cell
        msis_pkg::value_t prev_value;
        logic             prev_gt;
        msis_pkg::value_t next_value;

        if (i == 0) begin : g_head
            assign prev_value = '0;
            assign prev_gt    = 1'b0;
        end else begin : g_body
            assign prev_value = cell_value[i-1];
            assign prev_gt    = cell_gt[i-1];
        end

        if (i == SLOTS - 1) begin : g_tail
            assign next_value = '0;
        end else begin : g_inner
            assign next_value = cell_value[i+1];
        end

        msis_cell u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .occupied   (fill_count_reg > CNT_W'(i)),
            .new_value  (s_value),
            .prev_value (prev_value),
            .prev_gt    (prev_gt),
            .next_value (next_value),
            .value_out  (cell_value[i]),
            .gt_out     (cell_gt[i])
        );
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            msis_pkg::ST_LOAD: begin
                if (accept && s_last) begin
                    state_next = msis_pkg::ST_DRAIN;
                end
            end
            msis_pkg::ST_DRAIN: begin
                if (pop && fill_count_reg == CNT_W'(1)) begin
                    state_next = msis_pkg::ST_LOAD;
                end
            end
            default: begin
                state_next = msis_pkg::ST_LOAD;
            end
        endcase
    end

    // Counters, flags and output register.
    always_comb begin
        fill_count_next = fill_count_reg;
        dropped_next    = dropped_reg;
        m_valid_next    = m_valid_reg;
        m_value_next    = m_value_reg;
        m_end_next      = m_end_reg;
        m_ovf_next      = m_ovf_reg;

        case (state_reg)
            msis_pkg::ST_LOAD: begin
                if (accept) begin
                    if (full) begin
                        dropped_next = 1'b1;
                    end else begin
                        fill_count_next = fill_count_reg + CNT_W'(1);
                    end
                end
            end
            msis_pkg::ST_DRAIN: begin
                if (pop) begin
                    fill_count_next = fill_count_reg - CNT_W'(1);
                    if (fill_count_reg == CNT_W'(1)) begin
                        dropped_next = 1'b0;
                    end
                end
            end
            default: begin
                fill_count_next = '0;
                dropped_next    = 1'b0;
            end
        endcase

        if (pop) begin
            m_valid_next = 1'b1;
            m_value_next = cell_value[0];
            m_end_next   = (fill_count_reg == CNT_W'(1));
            m_ovf_next   = dropped_reg;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= msis_pkg::ST_LOAD;
            fill_count_reg <= '0;
            dropped_reg    <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            fill_count_reg <= fill_count_next;
            dropped_reg    <= dropped_next;
            m_valid_reg    <= m_valid_next;
        end
        m_value_reg <= m_value_next;
        m_end_reg   <= m_end_next;
        m_ovf_reg   <= m_ovf_next;
    end

    assign s_ready        = (state_reg == msis_pkg::ST_LOAD);
    assign m_valid        = m_valid_reg;
    assign m_sorted_value = m_value_reg;
    assign m_end_of_run   = m_end_reg;
    assign m_overflow     = m_ovf_reg;

endmodule

@@ rtl/msis_checker.sv @@
// Port-level assertions for the merge-insertion sorter, bound to the top level.
`timescale 1ns / 1ps

module msis_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          s_last,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [msis_pkg::VALUE_W-1:0]  m_sorted_value,
    input logic                          m_end_of_run,
    input logic                          m_overflow
);

    // Stalled result holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_sorted_value)
            && $stable(m_end_of_run) && $stable(m_overflow))
        else $error("stalled result changed");

    // Closing request starts a drain.
    a_close: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_last |=> !s_ready)
        else $error("input still ready after closing request");

    // More results pending while a non-final one waits.
    a_midrun: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_end_of_run |-> !s_ready)
        else $error("input ready in the middle of a run");

    // Draining with a free output register always produces a result.
    a_progress: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready && !m_valid |=> m_valid)
        else $error("drain stalled with free output");

endmodule

bind merge_insertion_sorter_unit msis_checker u_msis_checker (.*);
